FILE: sv/rsp_pkg.sv
// Shared types and constants for the reservoir sampler slot picker.
// No dependencies; imported by all modules but rsp_div.
package rsp_pkg;

  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned SLOT_AW    = 10;

  localparam logic [63:0] SEED_DEFAULT = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] RNG_ZERO_FIX = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] RNG_MULT     = 64'h2545_F491_4F6C_DD1D;
  localparam logic [47:0] BYTES_MAX    = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] REQ_OFFER = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_RESET = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [1:0] VERDICT_DROP    = 2'd0;
  localparam logic [1:0] VERDICT_APPEND  = 2'd1;
  localparam logic [1:0] VERDICT_REPLACE = 2'd2;

  localparam logic [1:0] REG_BYTE_BUDGET = 2'd0;
  localparam logic [1:0] REG_SLOT_LIMIT  = 2'd1;
  localparam logic [1:0] REG_WINDOW      = 2'd2;
  localparam logic [1:0] REG_RNG_SEED    = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] sample_len;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [9:0]  slot_index;
    logic [10:0] stored_count;
    logic [47:0] bytes_in_use;
    logic        ready_res;
    logic        active;
  } out_item_t;

  typedef struct packed {
    logic [31:0] byte_budget;
    logic [10:0] slot_limit;
    logic [31:0] window_ticks;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic eval;
    logic mix;
    logic mul0;
    logic mul1;
    logic mul2;
    logic div_start;
    logic div_by_i;
    logic rd;
    logic wr;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic go_replace;
    logic need_gate;
    logic gate_ok;
    logic div_done;
    logic out_busy;
  } ctl_sts_t;

endpackage

FILE: sv/rsp_div.sv
// Restoring serial divider, one quotient bit per cycle; only the remainder is kept.
// Depends on nothing but its ports.
module rsp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] rem_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] num_q, num_d;
  logic [63:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[63]};
    if (start_i) begin
      rem_d  = '0;
      num_d  = dividend_i;
      den_d  = divisor_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = 64'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[63:0];
      end
      num_d = {num_q[62:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: sv/rsp_ctrl.sv
// Sequencer for the slot picker: evaluate each item; replacements draw, divide, read, write.
// Depends on rsp_pkg for command and status structs.
module rsp_ctrl
  import rsp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_EVAL   = 12'b0000_0000_0010,
    S_MIX    = 12'b0000_0000_0100,
    S_MUL0   = 12'b0000_0000_1000,
    S_MUL1   = 12'b0000_0001_0000,
    S_MUL2   = 12'b0000_0010_0000,
    S_DSTART = 12'b0000_0100_0000,
    S_DWAIT  = 12'b0000_1000_0000,
    S_GATE   = 12'b0001_0000_0000,
    S_RD     = 12'b0010_0000_0000,
    S_WR     = 12'b0100_0000_0000,
    S_FIN    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   pass_q, pass_d;   // 0: gate draw, 1: slot draw

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.go_replace) begin
          pass_d  = !sts_i.need_gate;
          state_d = S_MIX;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = S_MUL0;
      end
      S_MUL0: begin
        cmd_o.mul0 = 1'b1;
        state_d    = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_by_i  = !pass_q;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          state_d = pass_q ? S_RD : S_GATE;
        end
      end
      S_GATE: begin
        if (sts_i.gate_ok) begin
          pass_d  = 1'b1;
          state_d = S_MIX;
        end else begin
          state_d = S_FIN;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_WR;
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

FILE: sv/rsp_dp.sv
// Datapath: session state, generator, slot length memory, divider and output register.
// Depends on rsp_pkg and rsp_div.
module rsp_dp
  import rsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_cmd_t    cmd_i,
  output ctl_sts_t    sts_o,
  input  in_item_t    in_data_i,
  input  cfg_t        cfg_i,
  input  logic        seed_wr_i,
  input  logic [63:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  logic [63:0] offers_q;
  logic [10:0] filled_q;
  logic [47:0] bytes_q;
  logic        frozen_q;
  logic        started_q;
  logic [31:0] start_q;
  logic [63:0] rng_q;
  logic [63:0] xs_q;
  logic [63:0] acc_q;

  logic [1:0]  req_q;
  logic [31:0] len_q;
  logic [31:0] now_q;
  logic [1:0]  verdict_q;
  logic [9:0]  slot_q;
  logic [31:0] rd_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic [31:0] mem [SLOT_COUNT];

  logic [10:0] lim;
  logic [31:0] elapsed;
  logic        active_now;
  logic        ready_now;
  logic        early;
  logic        fits;
  logic [48:0] bytes_plus;
  logic [63:0] offers_inc;
  logic [63:0] x0, x1, x2, x3;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [47:0] bytes_less;
  logic [48:0] bytes_repl;
  logic        div_done;
  logic [63:0] div_rem;
  logic [63:0] k64;
  logic        mem_we;
  logic [SLOT_AW-1:0] mem_waddr;

  always_comb begin
    if (cfg_i.slot_limit == 11'd0) begin
      lim = 11'd1;
    end else if (cfg_i.slot_limit > 11'(SLOT_COUNT)) begin
      lim = 11'(SLOT_COUNT);
    end else begin
      lim = cfg_i.slot_limit;
    end
  end

  assign elapsed    = now_q - start_q;
  assign active_now = started_q && ((cfg_i.window_ticks == 32'd0) ||
                                    (elapsed <= cfg_i.window_ticks));
  always_comb begin
    if (filled_q == 11'd0) begin
      ready_now = 1'b0;
    end else if (cfg_i.window_ticks == 32'd0) begin
      ready_now = frozen_q || (filled_q == lim);
    end else begin
      ready_now = started_q && (elapsed >= cfg_i.window_ticks);
    end
  end

  assign early      = (len_q == 32'd0) || !active_now || (len_q > cfg_i.byte_budget);
  assign bytes_plus = {1'b0, bytes_q} + {17'd0, len_q};
  assign fits       = !frozen_q && (filled_q < lim) &&
                      (bytes_plus <= {17'd0, cfg_i.byte_budget});
  assign offers_inc = offers_q + 64'd1;
  assign k64        = {53'd0, filled_q};

  assign sts_o.go_replace = (req_q == REQ_OFFER) && !early && !fits && (filled_q != 11'd0);
  assign sts_o.need_gate  = offers_inc > k64;
  assign sts_o.gate_ok    = div_rem < k64;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_busy   = out_valid_q && out_stall_i;

  // xorshift stage of the generator
  always_comb begin
    x0 = (rng_q == 64'd0) ? RNG_ZERO_FIX : rng_q;
    x1 = x0 ^ (x0 >> 12);
    x2 = x1 ^ (x1 << 25);
    x3 = x2 ^ (x2 >> 27);
  end

  // one 32x32 multiplier, low 64 bits of xs * RNG_MULT built over three steps
  always_comb begin
    mul_a = xs_q[31:0];
    mul_b = RNG_MULT[31:0];
    if (cmd_i.mul1) begin
      mul_a = xs_q[63:32];
    end else if (cmd_i.mul2) begin
      mul_b = RNG_MULT[63:32];
    end
  end
  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  assign bytes_less = (bytes_q >= {16'd0, rd_q}) ? (bytes_q - {16'd0, rd_q}) : 48'd0;
  assign bytes_repl = {1'b0, bytes_less} + {17'd0, len_q};

  rsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rng_q),
    .divisor_i  (cmd_i.div_by_i ? offers_q : k64),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offers_q    <= '0;
      filled_q    <= '0;
      bytes_q     <= '0;
      frozen_q    <= 1'b0;
      started_q   <= 1'b0;
      start_q     <= '0;
      rng_q       <= SEED_DEFAULT;
      out_valid_q <= 1'b0;
    end else begin
      if (seed_wr_i) begin
        rng_q <= (seed_i == 64'd0) ? SEED_DEFAULT : seed_i;
      end else if (cmd_i.mul2) begin
        rng_q <= {acc_q[63:32] + prod[31:0], acc_q[31:0]};
      end
      if (cmd_i.eval) begin
        case (req_q)
          REQ_OFFER: begin
            if (!early) begin
              offers_q <= offers_inc;
              if (fits) begin
                filled_q <= filled_q + 11'd1;
                bytes_q  <= (bytes_plus > {1'b0, BYTES_MAX}) ? BYTES_MAX : bytes_plus[47:0];
              end else if (!frozen_q && filled_q != 11'd0) begin
                frozen_q <= 1'b1;
              end
            end
          end
          REQ_START: begin
            if (!started_q) begin
              started_q <= 1'b1;
              start_q   <= now_q;
              offers_q  <= '0;
              filled_q  <= '0;
              bytes_q   <= '0;
              frozen_q  <= 1'b0;
            end
          end
          REQ_RESET: begin
            // slot lengths past the fill count are never read, so no clearing pass
            started_q <= 1'b0;
            start_q   <= '0;
            offers_q  <= '0;
            filled_q  <= '0;
            bytes_q   <= '0;
            frozen_q  <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.wr) begin
        bytes_q <= (bytes_repl > {1'b0, BYTES_MAX}) ? BYTES_MAX : bytes_repl[47:0];
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q     <= in_data_i.req_type;
      len_q     <= in_data_i.sample_len;
      now_q     <= in_data_i.now_time;
      verdict_q <= VERDICT_DROP;
      slot_q    <= '0;
    end
    if (cmd_i.eval && req_q == REQ_OFFER && !early && fits) begin
      verdict_q <= VERDICT_APPEND;
      slot_q    <= filled_q[SLOT_AW-1:0];
    end
    if (cmd_i.wr) begin
      verdict_q <= VERDICT_REPLACE;
      slot_q    <= div_rem[SLOT_AW-1:0];
    end
    if (cmd_i.mix) begin
      xs_q <= x3;
    end
    if (cmd_i.mul0) begin
      acc_q <= prod;
    end else if (cmd_i.mul1) begin
      acc_q <= {acc_q[63:32] + prod[31:0], acc_q[31:0]};
    end
    if (cmd_i.fin) begin
      out_q.verdict      <= verdict_q;
      out_q.slot_index   <= slot_q;
      out_q.stored_count <= filled_q;
      out_q.bytes_in_use <= bytes_q;
      out_q.ready_res    <= ready_now;
      out_q.active       <= active_now;
    end
  end

  assign mem_we    = (cmd_i.eval && req_q == REQ_OFFER && !early && fits) || cmd_i.wr;
  assign mem_waddr = cmd_i.wr ? div_rem[SLOT_AW-1:0] : filled_q[SLOT_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= len_q;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[div_rem[SLOT_AW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/reservoir_sampler_slot_picker.sv
// Reservoir sampler slot picker: one result per item. Session requests and appends
// need no random draw; a replacement draws once for the slot, and once more for the
// gate when the offer count exceeds the reservoir size (an offer that the gate drops
// draws once), the serial 64-bit divider running once per random draw. One item is in
// work at a time; the output register lets the next item enter while a result waits.
// Asynchronous active-low reset; no clearing pass.
module reservoir_sampler_slot_picker
  import rsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t        cfg_q;
  logic [63:0] seed_q;
  logic        wr_en;
  logic        seed_wr;
  ctl_cmd_t    cmd;
  ctl_sts_t    sts;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign seed_wr = wr_en && (paddr[4:3] == REG_RNG_SEED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.byte_budget  <= 32'd1048576;
      cfg_q.slot_limit   <= 11'd1024;
      cfg_q.window_ticks <= 32'd0;
      seed_q             <= SEED_DEFAULT;
    end else if (wr_en) begin
      case (paddr[4:3])
        REG_BYTE_BUDGET: cfg_q.byte_budget  <= pwdata[31:0];
        REG_SLOT_LIMIT:  cfg_q.slot_limit   <= pwdata[10:0];
        REG_WINDOW:      cfg_q.window_ticks <= pwdata[31:0];
        REG_RNG_SEED:    seed_q             <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_BYTE_BUDGET: prdata = {32'd0, cfg_q.byte_budget};
      REG_SLOT_LIMIT:  prdata = {53'd0, cfg_q.slot_limit};
      REG_WINDOW:      prdata = {32'd0, cfg_q.window_ticks};
      REG_RNG_SEED:    prdata = seed_q;
      default:         prdata = '0;
    endcase
  end

  rsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rsp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .seed_wr_i   (seed_wr),
    .seed_i      (pwdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for reservoir_sampler_slot_picker: queue-fed driver,
// monitor with scoreboard and an in-house slot-picking predictor. Depends on rsp_pkg and the top module.
module tb_top;
  import rsp_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  reservoir_sampler_slot_picker u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o), .in_data_i(in_data),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of configuration and state
  logic [31:0] budget_q = 32'd1048576;
  logic [10:0] limit_q = 11'd1024;
  logic [31:0] window_q = '0;
  logic [63:0] offers_q = '0;
  logic [10:0] filled_q = '0;
  logic [47:0] bytes_q = '0;
  logic        frozen_q = 1'b0;
  logic        started_q = 1'b0;
  logic [31:0] start_tick_q = '0;
  logic [63:0] rng_q = SEED_DEFAULT;
  logic [31:0] slot_len_q [SLOT_COUNT];

  in_item_t  pend_q[$];
  out_item_t verdict_q[$];
  int        fails = 0;
  int        gap = 0;
  bit        quiet = 0;
  bit        hold_req = 0;
  bit        hold_taken = 0;
  int        hold_left = 0;
  int        stall_left = 0;
  int        cycles = 0;
  int        offers_sent = 0;
  logic [31:0] tick = '0;

  initial foreach (slot_len_q[j]) slot_len_q[j] = '0;

  function automatic logic [63:0] xorshift_next(input logic [63:0] s);
    logic [63:0] x;
    x = (s == 0) ? RNG_ZERO_FIX : s;
    x ^= x >> 12;
    x ^= x << 25;
    x ^= x >> 27;
    return x * RNG_MULT;
  endfunction

  function automatic logic [10:0] eff_limit();
    if (limit_q < 1) return 11'd1;
    if (limit_q > SLOT_COUNT) return 11'(SLOT_COUNT);
    return limit_q;
  endfunction

  function automatic logic [47:0] sat48(input logic [63:0] v);
    return (v > {16'd0, BYTES_MAX}) ? BYTES_MAX : v[47:0];
  endfunction

  function automatic bit is_active(input logic [31:0] now);
    if (!started_q) return 0;
    if (window_q == 0) return 1;
    return (now - start_tick_q) <= window_q;
  endfunction

  function automatic bit is_ready(input logic [31:0] now);
    if (filled_q == 0) return 0;
    if (window_q == 0) return frozen_q || (filled_q == eff_limit());
    if (!started_q) return 0;
    return (now - start_tick_q) >= window_q;
  endfunction

  task automatic pick_slot(input in_item_t it, output out_item_t r);
    logic [63:0] cnt, k, rnd, old;
    logic [9:0]  idx;
    logic [1:0]  vd;
    vd = VERDICT_DROP;
    idx = '0;
    case (it.req_type)
      REQ_OFFER: begin
        if (it.sample_len != 0 && is_active(it.now_time) && it.sample_len <= budget_q) begin
          offers_q = offers_q + 1;
          cnt = offers_q;
          if (!frozen_q && filled_q < eff_limit() &&
              64'(bytes_q) + 64'(it.sample_len) <= 64'(budget_q)) begin
            idx = filled_q[9:0];
            slot_len_q[idx] = it.sample_len;
            filled_q = filled_q + 1;
            bytes_q = sat48(64'(bytes_q) + 64'(it.sample_len));
            vd = VERDICT_APPEND;
          end else begin
            if (!frozen_q && filled_q > 0) frozen_q = 1'b1;
            k = 64'(filled_q);
            if (k != 0) begin
              vd = VERDICT_REPLACE;
              if (cnt > k) begin
                rng_q = xorshift_next(rng_q);
                rnd = rng_q;
                if ((rnd % cnt) >= k) vd = VERDICT_DROP;
              end
              if (vd == VERDICT_REPLACE) begin
                rng_q = xorshift_next(rng_q);
                idx = 10'(rng_q % k);
                old = 64'(slot_len_q[idx]);
                bytes_q = sat48(((64'(bytes_q) >= old) ? 64'(bytes_q) - old : 64'd0)
                                + 64'(it.sample_len));
                slot_len_q[idx] = it.sample_len;
              end
            end
          end
        end
      end
      REQ_START: begin
        if (!started_q) begin
          started_q = 1'b1;
          start_tick_q = it.now_time;
          offers_q = '0; filled_q = '0; bytes_q = '0; frozen_q = 1'b0;
        end
      end
      REQ_RESET: begin
        foreach (slot_len_q[j]) slot_len_q[j] = '0;
        offers_q = '0; filled_q = '0; bytes_q = '0; frozen_q = 1'b0;
        started_q = 1'b0;
        start_tick_q = '0;
      end
      default: ;
    endcase
    r.verdict = vd;
    r.slot_index = (vd != VERDICT_DROP) ? idx : '0;
    r.stored_count = filled_q;
    r.bytes_in_use = bytes_q;
    r.ready_res = is_ready(it.now_time);
    r.active = is_active(it.now_time);
  endtask

  // driver: hold a stalled transfer, otherwise idle in bursts or present the next item
  always @(posedge clk_i) begin : drive
    out_item_t pr;
    int pos;
    pos = 0;
    if (in_valid && !in_stall_o) begin
      pick_slot(in_data, pr);
      verdict_q.push_back(pr);
      pos = 1;
    end
    if (in_valid && pos == 0) begin
    end else if (gap > 0) begin
      gap <= gap - 1;
      in_valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      gap <= $urandom_range(0, 17);
      in_valid <= 1'b0;
    end else if (pend_q.size() > pos) begin
      in_valid <= 1'b1;
      in_data <= pend_q[pos];
    end else begin
      in_valid <= 1'b0;
    end
    if (pos != 0) void'(pend_q.pop_front());
  end

  // monitor: compare each result transfer, then choose the next stall
  always @(posedge clk_i) begin : watch
    out_item_t ex;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("result with nothing expected: %0h", out_data_o);
        fails <= fails + 1;
      end else begin
        ex = verdict_q.pop_front();
        if (ex != out_data_o) begin
          if (ex.verdict != out_data_o.verdict)
            $error("verdict exp %0h got %0h", ex.verdict, out_data_o.verdict);
          if (ex.slot_index != out_data_o.slot_index)
            $error("slot_index exp %0h got %0h", ex.slot_index, out_data_o.slot_index);
          if (ex.stored_count != out_data_o.stored_count)
            $error("stored_count exp %0h got %0h", ex.stored_count, out_data_o.stored_count);
          if (ex.bytes_in_use != out_data_o.bytes_in_use)
            $error("bytes_in_use exp %0h got %0h", ex.bytes_in_use, out_data_o.bytes_in_use);
          if (ex.ready_res != out_data_o.ready_res)
            $error("ready_res exp %0h got %0h", ex.ready_res, out_data_o.ready_res);
          if (ex.active != out_data_o.active)
            $error("active exp %0h got %0h", ex.active, out_data_o.active);
          fails <= fails + 1;
        end
      end
    end
    if (hold_req && !hold_taken) begin
      hold_taken <= 1;
      hold_left <= 700;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 3; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_BYTE_BUDGET: budget_q = val[31:0];
      REG_SLOT_LIMIT:  limit_q = val[10:0];
      REG_WINDOW:      window_q = val[31:0];
      default:         rng_q = (val == 0) ? SEED_DEFAULT : val;
    endcase
  endtask

  task automatic push_item(input logic [1:0] rq, input logic [31:0] len);
    in_item_t it;
    it.req_type = rq;
    it.sample_len = len;
    it.now_time = tick;
    pend_q.push_back(it);
    if (rq == REQ_OFFER) offers_sent++;
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || verdict_q.size() != 0 || in_valid) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // random sessions: mostly start then a run of offers, with some noise
  task automatic run_sessions(input int n, input int max_len, input int max_step);
    int c;
    for (int m = 0; m < n; m++) begin
      c = $urandom_range(0, 99);
      tick = tick + $urandom_range(0, max_step);
      if (m % 90 == 0) push_item(REQ_START, $urandom);
      else if (c < 2) push_item(REQ_RESET, $urandom);
      else if (c < 5) push_item(REQ_START, $urandom);
      else if (c < 7) push_item(REQ_NONE, $urandom);
      else if (c < 10) push_item(REQ_OFFER, $urandom);
      else if (c < 12) push_item(REQ_OFFER, 32'd0);
      else push_item(REQ_OFFER, $urandom_range(1, max_len));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: inactive offer, unused code, double start, zero and oversized lengths
    tick = 32'hFFFF_FFF0;
    push_item(REQ_OFFER, 32'd10);
    push_item(REQ_NONE, 32'hFFFF_FFFF);
    push_item(REQ_START, 32'd0);
    push_item(REQ_START, 32'd0);
    push_item(REQ_OFFER, 32'd0);
    push_item(REQ_OFFER, 32'hFFFF_FFFF);
    push_item(REQ_OFFER, 32'd1);
    tick = tick + 32;
    push_item(REQ_OFFER, 32'd1048575);
    push_item(REQ_OFFER, 32'd1048576);
    push_item(REQ_OFFER, 32'd5);
    push_item(REQ_OFFER, 32'd7);
    push_item(REQ_RESET, 32'd0);
    push_item(REQ_OFFER, 32'd3);
    wait_drained();

    // small reservoir: fill, freeze, then mostly replacements
    apb_write(REG_BYTE_BUDGET, 64'd5000);
    apb_write(REG_SLOT_LIMIT, 64'd8);
    apb_write(REG_WINDOW, 64'd0);
    apb_write(REG_RNG_SEED, 64'd0);
    push_item(REQ_START, 32'd0);
    for (int m = 0; m < 8; m++) push_item(REQ_OFFER, 32'd1);
    // lower the limit mid-session: next offer freezes
    wait_drained();
    apb_write(REG_SLOT_LIMIT, 64'd3);
    push_item(REQ_OFFER, 32'd4);
    push_item(REQ_OFFER, 32'd4000);
    run_sessions(500, 2000, 3);
    wait_drained();

    // timed window with wide budget, and one long receiver hold-off
    apb_write(REG_BYTE_BUDGET, 64'hFFFF_FFFF);
    apb_write(REG_SLOT_LIMIT, 64'd1024);
    apb_write(REG_WINDOW, 64'd500);
    apb_write(REG_RNG_SEED, {$urandom, $urandom});
    run_sessions(550, 40000, 20);
    hold_req <= 1'b1;
    wait_drained();

    // single slot, one-byte budget, maximum window
    apb_write(REG_BYTE_BUDGET, 64'd1);
    apb_write(REG_SLOT_LIMIT, 64'd1);
    apb_write(REG_WINDOW, 64'hFFFF_FFFF);
    apb_write(REG_RNG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    run_sessions(450, 1, 1000);
    wait_drained();

    // last stretch without idling
    quiet = 1;
    apb_write(REG_BYTE_BUDGET, 64'd1048576);
    apb_write(REG_SLOT_LIMIT, 64'd16);
    apb_write(REG_WINDOW, 64'd0);
    apb_write(REG_RNG_SEED, SEED_DEFAULT);
    run_sessions(300, 200000, 5);
    wait_drained();

    $display("Covered %0d offers across five register settings, window and no-window sessions,",
             offers_sent);
    $display("a long output hold-off and random idling on both channels.");
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
